@@ design/wbps_pkg.sv @@
// Shared types and constants for the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int LEN_W       = 5;
    localparam int FIELD_BYTES = 8;
    localparam int INSN_LENGTH = 7;

    typedef enum logic [2:0] {
        REG_PATTERN_LOW     = 3'd0,
        REG_PATTERN_HIGH    = 3'd1,
        REG_WILDCARD_MASK   = 3'd2,
        REG_PATTERN_LENGTH  = 3'd3,
        REG_RESULT_MODE     = 3'd4,
        REG_FIELD_OFFSET    = 3'd5,
        REG_FIELD_SIZE_CODE = 3'd6,
        REG_ADD_OFFSET      = 3'd7
    } t_reg_idx;

    localparam logic [1:0] MODE_ADDR  = 2'd0;
    localparam logic [1:0] MODE_FIELD = 2'd1;
    localparam logic [1:0] MODE_REL   = 2'd2;

    localparam logic [1:0] SIZE_1 = 2'd0;
    localparam logic [1:0] SIZE_2 = 2'd1;
    localparam logic [1:0] SIZE_4 = 2'd2;
    localparam logic [1:0] SIZE_8 = 2'd3;

    typedef struct packed {
        logic [63:0]      pattern_low;
        logic [63:0]      pattern_high;
        logic [15:0]      wildcard_mask;
        logic [LEN_W-1:0] pattern_length;
        logic [1:0]       result_mode;
        logic [3:0]       field_offset;
        logic [1:0]       field_size_code;
        logic [3:0]       add_offset;
    } t_cfg;

    typedef struct packed {
        logic                       hit;
        logic [LEN_W-1:0]           len;
        logic [8*FIELD_BYTES-1:0]   field;
    } t_match;

endpackage

@@ design/wbps_byte_if.sv @@
// Input byte channel of the scanner.
interface wbps_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic [63:0] byte_address;
    logic        last_byte;

    modport source (output valid, output data_byte, output byte_address, output last_byte,
                    input ready);
    modport sink (input valid, input data_byte, input byte_address, input last_byte,
                  output ready);
endinterface

@@ design/wbps_result_if.sv @@
// Result channel of the scanner.
interface wbps_result_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [63:0] result_value;

    modport source (output valid, output found, output result_value, input ready);
    modport sink (input valid, input found, input result_value, output ready);
endinterface

@@ design/wbps_cfg_if.sv @@
// Register write channel of the scanner.
interface wbps_cfg_if;
    logic                 valid;
    logic                 ready;
    wbps_pkg::t_reg_idx   index;
    logic [63:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/wbps_match.sv @@
// Window compare against the wildcard pattern and field byte extraction.
module wbps_match #(
    parameter int MAX_PATTERN = 16
) (
    input  wbps_pkg::t_cfg              i_cfg,
    input  logic [MAX_PATTERN-1:0][7:0] i_window,
    output wbps_pkg::t_match            o_match
);
    import wbps_pkg::*;

    localparam int IDX_W = $clog2(MAX_PATTERN);

    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] base;
    logic [127:0]     pattern;

    assign pattern = {i_cfg.pattern_high, i_cfg.pattern_low};

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            len = LEN_W'(1);
        end else if (i_cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
            len = LEN_W'(MAX_PATTERN);
        end else begin
            len = i_cfg.pattern_length;
        end
        base = LEN_W'(MAX_PATTERN) - len;
    end

    // The newest len bytes sit at the top of the window, starting at base.
    // Field bytes that fall past the matched bytes read as zero.
    always_comb begin
        logic [LEN_W:0] pos;
        logic [LEN_W:0] p;
        logic [LEN_W:0] idx;
        logic           hit;
        hit = 1'b1;
        o_match.field = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            pos = {1'b0, base} + (LEN_W+1)'(i);
            if ((LEN_W'(i) < len) && !i_cfg.wildcard_mask[i]) begin
                if (i_window[pos[IDX_W-1:0]] != pattern[8*i +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        for (int k = 0; k < FIELD_BYTES; k++) begin
            p   = {2'b00, i_cfg.field_offset} + (LEN_W+1)'(k);
            idx = {1'b0, base} + p;
            if (p < {1'b0, len}) begin
                o_match.field[8*k +: 8] = i_window[idx[IDX_W-1:0]];
            end
        end
        o_match.hit = hit;
        o_match.len = len;
    end

endmodule

@@ design/wildcard_byte_pattern_scanner.sv @@
// Wildcard byte pattern scanner: bytes with addresses stream in one per cycle unless stalled and
// are shifted into a window of the last MAX_PATTERN bytes; the first place in a region where the
// newest pattern_length bytes match the pattern (wildcard bytes match anything) gives one found
// result, and a region ending on last_byte without a match gives one not-found result.
// The block accepts one byte every cycle while input ready is high. A result passes through a
// first stage, where the compare and the match address sum are registered, and then the output
// register, filled by the field zero or sign extension and, in relative mode, the final 64-bit
// add. Input ready drops only while both stages hold results that the output side has not taken.
// Configuration is written through the register channel, which is always ready.
module wildcard_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wbps_cfg_if.sink      i_cfg,
    wbps_byte_if.sink     i_in,
    wbps_result_if.source o_out
);
    import wbps_pkg::*;

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    t_cfg r_cfg;

    logic [MAX_PATTERN-1:0][7:0] r_window;
    logic [MAX_PATTERN-1:0][7:0] n_window;
    logic [FILL_W-1:0]           r_fill;
    logic [FILL_W-1:0]           n_fill;
    logic                        r_match_done;

    logic        r_s1_valid;
    logic        r_s1_found;
    logic [63:0] r_s1_base;
    logic [63:0] r_s1_field;

    logic        r_o_valid;
    logic        r_o_found;
    logic [63:0] r_o_value;
    logic [63:0] n_o_value;

    t_match      match;
    logic        in_acc;
    logic        in_ready;
    logic        s1_adv;
    logic        fill_ok;
    logic        hit;
    logic        emit;
    logic [6:0]  base_off;
    logic [63:0] fld_zext;
    logic [63:0] fld_sext;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low     <= '0;
            r_cfg.pattern_high    <= '0;
            r_cfg.wildcard_mask   <= '0;
            r_cfg.pattern_length  <= LEN_W'(1);
            r_cfg.result_mode     <= MODE_ADDR;
            r_cfg.field_offset    <= '0;
            r_cfg.field_size_code <= SIZE_4;
            r_cfg.add_offset      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_PATTERN_LOW:     r_cfg.pattern_low     <= i_cfg.data;
                REG_PATTERN_HIGH:    r_cfg.pattern_high    <= i_cfg.data;
                REG_WILDCARD_MASK:   r_cfg.wildcard_mask   <= i_cfg.data[15:0];
                REG_PATTERN_LENGTH:  r_cfg.pattern_length  <= i_cfg.data[LEN_W-1:0];
                REG_RESULT_MODE:     r_cfg.result_mode     <= i_cfg.data[1:0];
                REG_FIELD_OFFSET:    r_cfg.field_offset    <= i_cfg.data[3:0];
                REG_FIELD_SIZE_CODE: r_cfg.field_size_code <= i_cfg.data[1:0];
                REG_ADD_OFFSET:      r_cfg.add_offset      <= i_cfg.data[3:0];
            endcase
        end
    end

    // Handshake and pipeline control.
    assign s1_adv     = r_s1_valid && (!r_o_valid || o_out.ready);
    assign in_ready   = !r_s1_valid || s1_adv;
    assign i_in.ready = in_ready;
    assign in_acc     = i_in.valid && in_ready;

    assign n_window = {i_in.data_byte, r_window[MAX_PATTERN-1:1]};
    assign n_fill   = (r_fill == FILL_W'(MAX_PATTERN)) ? r_fill : r_fill + FILL_W'(1);

    wbps_match #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_match (
        .i_cfg    (r_cfg),
        .i_window (n_window),
        .o_match  (match)
    );

    assign fill_ok = (6'(n_fill) >= 6'(match.len));
    assign hit     = !r_match_done && fill_ok && match.hit;
    assign emit    = hit || (i_in.last_byte && !r_match_done);

    // Signed offset from the current byte address to the reported base address.
    always_comb begin
        if (r_cfg.result_mode == MODE_REL) begin
            base_off = 7'(INSN_LENGTH + 1) - {2'b00, match.len};
        end else begin
            base_off = {3'b000, r_cfg.add_offset} + 7'd1 - {2'b00, match.len};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= '0;
            r_fill       <= '0;
            r_match_done <= 1'b0;
        end else if (in_acc) begin
            if (i_in.last_byte) begin
                r_window     <= '0;
                r_fill       <= '0;
                r_match_done <= 1'b0;
            end else begin
                r_window     <= n_window;
                r_fill       <= n_fill;
                r_match_done <= r_match_done || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= emit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_found <= hit;
            r_s1_base  <= i_in.byte_address + {{57{base_off[6]}}, base_off};
            r_s1_field <= match.field;
        end
    end

    always_comb begin
        unique case (r_cfg.field_size_code)
            SIZE_1: begin
                fld_zext = {56'b0, r_s1_field[7:0]};
                fld_sext = {{56{r_s1_field[7]}}, r_s1_field[7:0]};
            end
            SIZE_2: begin
                fld_zext = {48'b0, r_s1_field[15:0]};
                fld_sext = {{48{r_s1_field[15]}}, r_s1_field[15:0]};
            end
            SIZE_4: begin
                fld_zext = {32'b0, r_s1_field[31:0]};
                fld_sext = {{32{r_s1_field[31]}}, r_s1_field[31:0]};
            end
            SIZE_8: begin
                fld_zext = r_s1_field;
                fld_sext = r_s1_field;
            end
        endcase
    end

    always_comb begin
        n_o_value = '0;
        if (r_s1_found) begin
            unique case (r_cfg.result_mode)
                MODE_FIELD: n_o_value = fld_zext;
                MODE_REL:   n_o_value = r_s1_base + fld_sext;
                default:    n_o_value = r_s1_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_found <= r_s1_found;
            r_o_value <= n_o_value;
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.found        = r_o_found;
    assign o_out.result_value = r_o_value;

`ifndef ASSERT_OFF
    a_last_clears_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.last_byte |=> (r_fill == '0) && !r_match_done)
        else $error("region state not cleared after last byte");

    a_hit_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && hit && !i_in.last_byte |=> r_match_done)
        else $error("match not recorded for the region");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> r_s1_valid && r_o_valid && !o_out.ready)
        else $error("input stalled while a stage is free");

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && !r_o_found |-> r_o_value == '0)
        else $error("not-found result carries a nonzero value");
`endif

endmodule
